[hdl/p3ik_pkg.sv]
// Shared constants and types for the planar three-link inverse kinematics core.
`default_nettype none
package p3ik_pkg;

  localparam int STEPS = 24;
  localparam int AW = 36;
  localparam int ATAN2_LAT = STEPS + 3;

  localparam logic signed [AW-1:0] PI_Q30 = 36'sd3373259426;
  localparam logic signed [AW-1:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [34:0] GAIN_Q30 = 35'sd652032874;

  localparam logic signed [AW-1:0] ATAN_TAB [0:STEPS-1] = '{
    36'sd843314857, 36'sd497837830, 36'sd263043837, 36'sd133525159, 36'sd67021687,
    36'sd33543515, 36'sd16775851, 36'sd8388437, 36'sd4194284, 36'sd2097149,
    36'sd1048576, 36'sd524288, 36'sd262144, 36'sd131072, 36'sd65536, 36'sd32768,
    36'sd16384, 36'sd8192, 36'sd4096, 36'sd2048, 36'sd1024, 36'sd512, 36'sd256,
    36'sd128
  };

  typedef enum logic [1:0] {
    REG_UPPER = 2'd0,
    REG_LOWER = 2'd1,
    REG_TOOL  = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic signed [14:0] th;
    logic signed [21:0] wx;
    logic signed [21:0] wy;
    logic               unr;
  } sb_t;

endpackage
`default_nettype wire

[hdl/p3ik_atan2.sv]
// Pipelined atan2 by CORDIC vectoring with quadrant pre-rotation and operand normalization.
`default_nettype none
module p3ik_atan2 import p3ik_pkg::*; #(
  parameter int W = 32
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [W-1:0]  y_i,
  input  logic signed [W-1:0]  x_i,
  output logic signed [AW-1:0] z_o
);

  localparam int IW = ((W > 31) ? W : 31) + 3;

  function automatic logic [IW-1:0] mag(input logic signed [IW-1:0] v);
    mag = v[IW-1] ? IW'(-v) : IW'(v);
  endfunction

  logic signed [IW-1:0] xe, ye, px_nxt, py_nxt, px_r, py_r;
  logic signed [AW-1:0] pz_nxt, pz_r;
  logic                 pzero_r;

  assign xe = IW'(x_i);
  assign ye = IW'(y_i);

  always_comb begin
    px_nxt = xe;
    py_nxt = ye;
    pz_nxt = '0;
    if (xe < 0) begin
      if (ye >= 0) begin
        px_nxt = ye;
        py_nxt = -xe;
        pz_nxt = HALF_PI_Q30;
      end else begin
        px_nxt = -ye;
        py_nxt = xe;
        pz_nxt = -HALF_PI_Q30;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px_r    <= px_nxt;
      py_r    <= py_nxt;
      pz_r    <= pz_nxt;
      pzero_r <= (x_i == '0) && (y_i == '0);
    end
  end

  // normalize: first half
  logic signed [IW-1:0] n1x_nxt, n1y_nxt, n1x_r, n1y_r;
  logic [IW-1:0]        n1m_nxt, n1m_r;
  logic signed [AW-1:0] n1z_r;
  logic                 n1zero_r;

  always_comb begin
    n1x_nxt = px_r;
    n1y_nxt = py_r;
    n1m_nxt = mag(px_r) | mag(py_r);
    if (n1m_nxt < (IW'(1) << 13)) begin
      n1x_nxt = n1x_nxt <<< 16;
      n1y_nxt = n1y_nxt <<< 16;
      n1m_nxt = n1m_nxt << 16;
    end
    if (n1m_nxt < (IW'(1) << 21)) begin
      n1x_nxt = n1x_nxt <<< 8;
      n1y_nxt = n1y_nxt <<< 8;
      n1m_nxt = n1m_nxt << 8;
    end
    if (n1m_nxt < (IW'(1) << 25)) begin
      n1x_nxt = n1x_nxt <<< 4;
      n1y_nxt = n1y_nxt <<< 4;
      n1m_nxt = n1m_nxt << 4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n1x_r    <= n1x_nxt;
      n1y_r    <= n1y_nxt;
      n1m_r    <= n1m_nxt;
      n1z_r    <= pz_r;
      n1zero_r <= pzero_r;
    end
  end

  logic signed [IW-1:0] cx_r [0:STEPS];
  logic signed [IW-1:0] cy_r [0:STEPS];
  logic signed [AW-1:0] cz_r [0:STEPS];
  logic                 czero_r [0:STEPS];
  logic signed [IW-1:0] n2x_nxt, n2y_nxt;
  logic [IW-1:0]        n2m;

  always_comb begin
    n2x_nxt = n1x_r;
    n2y_nxt = n1y_r;
    n2m     = n1m_r;
    if (n2m < (IW'(1) << 27)) begin
      n2x_nxt = n2x_nxt <<< 2;
      n2y_nxt = n2y_nxt <<< 2;
      n2m     = n2m << 2;
    end
    if (n2m < (IW'(1) << 28)) begin
      n2x_nxt = n2x_nxt <<< 1;
      n2y_nxt = n2y_nxt <<< 1;
      n2m     = n2m << 1;
    end
    if (n2m < (IW'(1) << 29)) begin
      n2x_nxt = n2x_nxt <<< 1;
      n2y_nxt = n2y_nxt <<< 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cx_r[0]    <= n2x_nxt;
      cy_r[0]    <= n2y_nxt;
      cz_r[0]    <= n1z_r;
      czero_r[0] <= n1zero_r;
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic signed [IW-1:0] x_nxt, y_nxt;
    logic signed [AW-1:0] z_nxt;

    always_comb begin
      if (cy_r[i] > 0) begin
        x_nxt = cx_r[i] + (cy_r[i] >>> i);
        y_nxt = cy_r[i] - (cx_r[i] >>> i);
        z_nxt = cz_r[i] + ATAN_TAB[i];
      end else begin
        x_nxt = cx_r[i] - (cy_r[i] >>> i);
        y_nxt = cy_r[i] + (cx_r[i] >>> i);
        z_nxt = cz_r[i] - ATAN_TAB[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        cx_r[i+1]    <= x_nxt;
        cy_r[i+1]    <= y_nxt;
        cz_r[i+1]    <= z_nxt;
        czero_r[i+1] <= czero_r[i];
      end
    end
  end

  assign z_o = czero_r[STEPS] ? '0 : cz_r[STEPS];

endmodule
`default_nettype wire

[hdl/planar_three_link_inverse_kinematics_core.sv]
// Top level of the planar three-link inverse kinematics core.
// Usage:
//   in_* stream carries one target per transaction: x, y (Q14 meters) and heading
//   (Q12 radians). out_* stream returns base, elbow and wrist angles (Q12 radians)
//   in tdata and the reachable flag in tuser, one result per target, in order.
//   cfg_* is an APB-style port for the three link lengths (Q14 meters) at byte
//   addresses 0, 4 and 8; write them only while the pipeline is empty.
// Throughput: one target per cycle unless stalled; every stage is one register of
//   a single pipeline (heading CORDIC, wrist products, 31-stage bit-serial divider,
//   31-stage square root, three parallel 27-stage atan2 units, angle assembly).
// Reset: rst_n clears all valid bits and loads the default link lengths.
// Stall: when out_tready is low with a result waiting, the whole pipeline
//   holds and in_tready drops; bubbles move forward while the output is empty.
`default_nettype none
module planar_three_link_inverse_kinematics_core import p3ik_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,     // target_x[17:0], target_y[35:18], target_heading[50:36]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,    // base_angle[16:0], elbow_angle[30:17], wrist_angle[47:31]
  output logic        out_tuser,    // reachable[0]
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int VLD_DEPTH = 125;

  logic [15:0] l1_r, l2_r, l3_r;
  logic        adv;
  reg_idx_t    cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      l1_r <= 16'd7045;
      l2_r <= 16'd5407;
      l3_r <= 16'd3932;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      case (cfg_idx)
        REG_UPPER: l1_r <= cfg_pwdata[15:0];
        REG_LOWER: l2_r <= cfg_pwdata[15:0];
        REG_TOOL:  l3_r <= cfg_pwdata[15:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_UPPER: cfg_prdata = {16'b0, l1_r};
      REG_LOWER: cfg_prdata = {16'b0, l2_r};
      REG_TOOL:  cfg_prdata = {16'b0, l3_r};
      default:   cfg_prdata = '0;
    endcase
  end

  // pipeline control
  logic [VLD_DEPTH-1:0] vld_r;
  logic                 out_valid_r;

  assign adv        = !out_valid_r || out_tready;
  assign in_tready  = adv;
  assign out_tvalid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r       <= {vld_r[VLD_DEPTH-2:0], in_tvalid};
      out_valid_r <= vld_r[VLD_DEPTH-1];
    end
  end

  // heading sine and cosine
  logic signed [17:0] in_x, in_y;
  logic signed [14:0] in_th;
  logic signed [AW-1:0] ang, ang_nxt;
  logic flip_nxt;

  assign in_x  = in_tdata[17:0];
  assign in_y  = in_tdata[35:18];
  assign in_th = in_tdata[50:36];
  assign ang   = {{3{in_th[14]}}, in_th, 18'b0};

  always_comb begin
    ang_nxt  = ang;
    flip_nxt = 1'b0;
    if (ang > HALF_PI_Q30) begin
      ang_nxt  = ang - PI_Q30;
      flip_nxt = 1'b1;
    end else if (ang < -HALF_PI_Q30) begin
      ang_nxt  = ang + PI_Q30;
      flip_nxt = 1'b1;
    end
  end

  logic signed [34:0]   sc_x_r [0:STEPS];
  logic signed [34:0]   sc_y_r [0:STEPS];
  logic signed [AW-1:0] sc_z_r [0:STEPS];
  logic signed [17:0]   sc_tx_r [0:STEPS];
  logic signed [17:0]   sc_ty_r [0:STEPS];
  logic signed [14:0]   sc_th_r [0:STEPS];
  logic                 sc_flip_r [0:STEPS];

  always_ff @(posedge clk) begin
    if (adv) begin
      sc_x_r[0]    <= GAIN_Q30;
      sc_y_r[0]    <= '0;
      sc_z_r[0]    <= ang_nxt;
      sc_tx_r[0]   <= in_x;
      sc_ty_r[0]   <= in_y;
      sc_th_r[0]   <= in_th;
      sc_flip_r[0] <= flip_nxt;
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_sc
    logic signed [34:0]   x_nxt, y_nxt;
    logic signed [AW-1:0] z_nxt;

    always_comb begin
      if (sc_z_r[i] >= 0) begin
        x_nxt = sc_x_r[i] - (sc_y_r[i] >>> i);
        y_nxt = sc_y_r[i] + (sc_x_r[i] >>> i);
        z_nxt = sc_z_r[i] - ATAN_TAB[i];
      end else begin
        x_nxt = sc_x_r[i] + (sc_y_r[i] >>> i);
        y_nxt = sc_y_r[i] - (sc_x_r[i] >>> i);
        z_nxt = sc_z_r[i] + ATAN_TAB[i];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sc_x_r[i+1]    <= x_nxt;
        sc_y_r[i+1]    <= y_nxt;
        sc_z_r[i+1]    <= z_nxt;
        sc_tx_r[i+1]   <= sc_tx_r[i];
        sc_ty_r[i+1]   <= sc_ty_r[i];
        sc_th_r[i+1]   <= sc_th_r[i];
        sc_flip_r[i+1] <= sc_flip_r[i];
      end
    end
  end

  // wrist point and law of cosines
  logic signed [35:0] w0_c_r, w0_s_r;
  logic signed [17:0] w0_tx_r, w0_ty_r, w1_tx_r, w1_ty_r;
  logic signed [14:0] w0_th_r, w1_th_r, w2_th_r, w3_th_r, w4_th_r;
  logic signed [52:0] w1_pc_r, w1_ps_r;
  logic signed [52:0] rc, rs;
  logic signed [21:0] w2_wx_r, w2_wy_r, w3_wx_r, w3_wy_r, w4_wx_r, w4_wy_r;
  logic signed [43:0] w3_sx_r, w3_sy_r;
  logic [31:0]        w3_l1sq_r, w3_l2sq_r, w3_l12_r;
  logic [32:0]        lsum;
  logic signed [45:0] w4_num_r;
  logic [36:0]        w4_den_r;
  logic [44:0]        num_mag;

  always_ff @(posedge clk) begin
    if (adv) begin
      w0_c_r  <= sc_flip_r[STEPS] ? -36'(sc_x_r[STEPS]) : 36'(sc_x_r[STEPS]);
      w0_s_r  <= sc_flip_r[STEPS] ? -36'(sc_y_r[STEPS]) : 36'(sc_y_r[STEPS]);
      w0_tx_r <= sc_tx_r[STEPS];
      w0_ty_r <= sc_ty_r[STEPS];
      w0_th_r <= sc_th_r[STEPS];

      w1_pc_r <= $signed({1'b0, l3_r}) * w0_c_r;
      w1_ps_r <= $signed({1'b0, l3_r}) * w0_s_r;
      w1_tx_r <= w0_tx_r;
      w1_ty_r <= w0_ty_r;
      w1_th_r <= w0_th_r;

      w2_wx_r <= (22'(w1_tx_r) <<< 2) - 22'(rc >>> 28);
      w2_wy_r <= (22'(w1_ty_r) <<< 2) - 22'(rs >>> 28);
      w2_th_r <= w1_th_r;

      w3_sx_r   <= w2_wx_r * w2_wx_r;
      w3_sy_r   <= w2_wy_r * w2_wy_r;
      w3_l1sq_r <= l1_r * l1_r;
      w3_l2sq_r <= l2_r * l2_r;
      w3_l12_r  <= l1_r * l2_r;
      w3_wx_r   <= w2_wx_r;
      w3_wy_r   <= w2_wy_r;
      w3_th_r   <= w2_th_r;

      w4_num_r <= 46'(w3_sx_r) + 46'(w3_sy_r) - $signed(46'({lsum, 4'b0}));
      w4_den_r <= {w3_l12_r, 5'b0};
      w4_wx_r  <= w3_wx_r;
      w4_wy_r  <= w3_wy_r;
      w4_th_r  <= w3_th_r;
    end
  end

  assign rc      = w1_pc_r + 53'sd134217728;
  assign rs      = w1_ps_r + 53'sd134217728;
  assign lsum    = {1'b0, w3_l1sq_r} + {1'b0, w3_l2sq_r};
  assign num_mag = w4_num_r[45] ? 45'(-w4_num_r) : 45'(w4_num_r);

  // bit-serial divider, one quotient bit per stage
  logic [38:0] dv_rem_r [0:31];
  logic [36:0] dv_den_r [0:31];
  logic [30:0] dv_q_r [0:31];
  logic        dv_neg_r [0:31];
  sb_t         dv_sb_r [0:31];

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_rem_r[0] <= num_mag[38:0];
      dv_den_r[0] <= w4_den_r;
      dv_q_r[0]   <= '0;
      dv_neg_r[0] <= w4_num_r[45];
      dv_sb_r[0]  <= '{th: w4_th_r, wx: w4_wx_r, wy: w4_wy_r,
                       unr: (w4_den_r == '0) || (num_mag > 45'(w4_den_r))};
    end
  end

  for (genvar i = 0; i < 31; i++) begin : g_div
    logic        ge;
    logic [38:0] sub;

    assign ge  = dv_rem_r[i] >= {2'b0, dv_den_r[i]};
    assign sub = ge ? dv_rem_r[i] - {2'b0, dv_den_r[i]} : dv_rem_r[i];

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_rem_r[i+1] <= {sub[37:0], 1'b0};
        dv_den_r[i+1] <= dv_den_r[i];
        dv_q_r[i+1]   <= {dv_q_r[i][29:0], ge};
        dv_neg_r[i+1] <= dv_neg_r[i];
        dv_sb_r[i+1]  <= dv_sb_r[i];
      end
    end
  end

  // D squared and square root of 1 - D^2
  logic signed [31:0] m_d_r;
  logic [61:0]        m_qsq_r;
  sb_t                m_sb_r;
  logic [31:0]        q_ext;

  assign q_ext = {1'b0, dv_q_r[31]};

  always_ff @(posedge clk) begin
    if (adv) begin
      m_d_r   <= dv_neg_r[31] ? -$signed(q_ext) : $signed(q_ext);
      m_qsq_r <= dv_q_r[31] * dv_q_r[31];
      m_sb_r  <= dv_sb_r[31];
    end
  end

  logic [60:0]        sq_v_r [0:31];
  logic [60:0]        sq_r_r [0:31];
  logic signed [31:0] sq_d_r [0:31];
  sb_t                sq_sb_r [0:31];

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_v_r[0]  <= (61'(1) << 60) - m_qsq_r[60:0];
      sq_r_r[0]  <= '0;
      sq_d_r[0]  <= m_d_r;
      sq_sb_r[0] <= m_sb_r;
    end
  end

  for (genvar k = 0; k < 31; k++) begin : g_sqrt
    localparam logic [60:0] BK = 61'(1) << (60 - 2 * k);
    logic [61:0] t;
    logic        ge;

    assign t  = {1'b0, sq_r_r[k]} + {1'b0, BK};
    assign ge = {1'b0, sq_v_r[k]} >= t;

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_v_r[k+1]  <= ge ? sq_v_r[k] - t[60:0] : sq_v_r[k];
        sq_r_r[k+1]  <= ge ? (sq_r_r[k] >> 1) + BK : sq_r_r[k] >> 1;
        sq_d_r[k+1]  <= sq_d_r[k];
        sq_sb_r[k+1] <= sq_sb_r[k];
      end
    end
  end

  // second-link projection for the base correction angle
  logic signed [48:0] k1_pd_r;
  logic [46:0]        k1_ps_r;
  logic signed [31:0] k1_d_r, k2_d_r;
  logic [30:0]        k1_sn_r, k2_sn_r;
  sb_t                k1_sb_r, k2_sb_r;
  logic signed [35:0] k2_k1_r, k2_k2_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      k1_pd_r <= $signed({1'b0, l2_r}) * sq_d_r[31];
      k1_ps_r <= l2_r * sq_r_r[31][30:0];
      k1_d_r  <= sq_d_r[31];
      k1_sn_r <= sq_r_r[31][30:0];
      k1_sb_r <= sq_sb_r[31];

      k2_k1_r <= $signed({4'b0, l1_r, 16'b0}) + 36'(k1_pd_r >>> 14);
      k2_k2_r <= $signed({3'b0, k1_ps_r[46:14]});
      k2_d_r  <= k1_d_r;
      k2_sn_r <= k1_sn_r;
      k2_sb_r <= k1_sb_r;
    end
  end

  // three atan2 units in parallel
  logic signed [AW-1:0] z_elb, z_wr, z_k;

  p3ik_atan2 #(.W(32)) u_atan_elbow (
    .clk (clk),
    .en  (adv),
    .y_i ($signed({1'b0, k2_sn_r})),
    .x_i (k2_d_r),
    .z_o (z_elb)
  );

  p3ik_atan2 #(.W(22)) u_atan_wrist (
    .clk (clk),
    .en  (adv),
    .y_i (k2_sb_r.wy),
    .x_i (k2_sb_r.wx),
    .z_o (z_wr)
  );

  p3ik_atan2 #(.W(36)) u_atan_link (
    .clk (clk),
    .en  (adv),
    .y_i (k2_k2_r),
    .x_i (k2_k1_r),
    .z_o (z_k)
  );

  logic signed [14:0] at_th_r [0:ATAN2_LAT-1];
  logic               at_unr_r [0:ATAN2_LAT-1];

  always_ff @(posedge clk) begin
    if (adv) begin
      at_th_r[0]  <= k2_sb_r.th;
      at_unr_r[0] <= k2_sb_r.unr;
      for (int j = 1; j < ATAN2_LAT; j++) begin
        at_th_r[j]  <= at_th_r[j-1];
        at_unr_r[j] <= at_unr_r[j-1];
      end
    end
  end

  // angle assembly
  logic signed [36:0]   f_diff_r;
  logic signed [AW-1:0] f_a2_r;
  logic signed [14:0]   f_th_r;
  logic                 f_unr_r;
  logic signed [AW-1:0] a2_nxt;

  always_comb begin
    a2_nxt = z_elb;
    if (z_elb < 0) begin
      a2_nxt = '0;
    end else if (z_elb > PI_Q30) begin
      a2_nxt = PI_Q30;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f_diff_r <= 37'(z_wr) - 37'(z_k);
      f_a2_r   <= a2_nxt;
      f_th_r   <= at_th_r[ATAN2_LAT-1];
      f_unr_r  <= at_unr_r[ATAN2_LAT-1];
    end
  end

  logic signed [36:0]   q1_sum;
  logic signed [AW-1:0] q2_sum;
  logic [16:0]          q1, q2w, q3;
  logic [47:0]          out_data_r;
  logic                 out_user_r;

  assign q1_sum = f_diff_r + 37'sd131072;
  assign q2_sum = f_a2_r + 36'sd131072;
  assign q1     = q1_sum[34:18];
  assign q2w    = {3'b0, q2_sum[31:18]};
  assign q3     = 17'(f_th_r) - q1 - q2w;

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= f_unr_r ? '0 : {q3, q2w[13:0], q1};
      out_user_r <= !f_unr_r;
    end
  end

  assign out_tdata = out_data_r;
  assign out_tuser = out_user_r;

endmodule
`default_nettype wire
